// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the transform RTL. They expand to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is high
`define ACT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset
`define ACT_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ACT_ASSERT(name, clk, rst, prop, msg)

`define ACT_ASSERT_NR(name, clk, prop, msg)

`endif

`endif

// File: src/act_pkg.sv
// ---------------------------------------------------------------------------
// act_pkg
// Shared widths, angle constants and control types for the abc-to-dq
// current transform.
// ---------------------------------------------------------------------------
package act_pkg;

  // Default configuration
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_SAMPLE_BITS      = 16;

  // Fixed field widths
  localparam int ANGLE_W = 16;   // angle, fraction of one turn
  localparam int SINE_W  = 16;   // sine table entry, signed Q15

  // Angle offsets in turn units
  localparam logic [ANGLE_W-1:0] ANGLE_THIRD   = 16'd21845;  // 120 deg
  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'd16384;  // 90 deg

  // pi/2 in Q30, seed of the table generator
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Register stages from input transfer to output register
  localparam int PIPE_STAGES = 7;

  // Load enables for the scaling stages of one axis
  typedef struct packed {
    logic sum_en;
    logic round_en;
    logic mul_en;
    logic out_en;
  } scale_ctrl_t;

endpackage

// File: src/act_sine_rom.sv
// ---------------------------------------------------------------------------
// act_sine_rom
// Full-turn Q15 sine table with two registered read ports. Contents are
// generated at elaboration from a quadrant-folded Taylor series in Q30.
// ---------------------------------------------------------------------------
module act_sine_rom #(
  parameter int SINE_TABLE_DEPTH = act_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr_a,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr_b,
  output logic signed [act_pkg::SINE_W-1:0]     data_a,
  output logic signed [act_pkg::SINE_W-1:0]     data_b
);
  import act_pkg::*;

  // Table entry k = sin(2*pi*k/depth), Q15, rounded half up from Q30
  function automatic logic signed [SINE_W-1:0] sine_entry(input int k);
    longint u;
    longint quad;
    longint r;
    longint theta;
    longint theta2;
    longint term;
    longint acc;
    longint mag;
    u    = 4 * longint'(k);
    quad = u / SINE_TABLE_DEPTH;
    r    = u % SINE_TABLE_DEPTH;
    if (quad[0]) begin
      r = SINE_TABLE_DEPTH - r;
    end
    theta  = (HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
    theta2 = (theta * theta) >>> 30;
    acc    = theta;
    term   = theta;
    // Seven terms after the linear one, truncating products
    term = ((term * theta2) >>> 30) / 6;   acc = acc - term;
    term = ((term * theta2) >>> 30) / 20;  acc = acc + term;
    term = ((term * theta2) >>> 30) / 42;  acc = acc - term;
    term = ((term * theta2) >>> 30) / 72;  acc = acc + term;
    term = ((term * theta2) >>> 30) / 110; acc = acc - term;
    term = ((term * theta2) >>> 30) / 156; acc = acc + term;
    term = ((term * theta2) >>> 30) / 210; acc = acc - term;
    if (acc < 0) begin
      acc = 0;
    end
    mag = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (quad >= 2) begin
      mag = -mag;
    end
    return SINE_W'(mag);
  endfunction

  logic signed [SINE_W-1:0] rom [SINE_TABLE_DEPTH];

  // Constant contents
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(k);
  end

  // Registered reads, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

// File: src/act_phase_index.sv
// ---------------------------------------------------------------------------
// act_phase_index
// Derives the three phase angles (0, -120, +120 deg) and their quarter-turn
// shifted cosine angles, and maps each onto a sine table index.
// ---------------------------------------------------------------------------
module act_phase_index #(
  parameter int SINE_TABLE_DEPTH = act_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic [act_pkg::ANGLE_W-1:0]                 rotor_angle,
  output logic [2:0][$clog2(SINE_TABLE_DEPTH)-1:0]    sin_idx,
  output logic [2:0][$clog2(SINE_TABLE_DEPTH)-1:0]    cos_idx
);
  import act_pkg::*;

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = ANGLE_W + DEPTH_W;

  // Per-phase offsets: phase a, phase b (-120 deg), phase c (+120 deg)
  localparam logic [2:0][ANGLE_W-1:0] PHASE_OFS =
    {ANGLE_THIRD, ANGLE_W'(0) - ANGLE_THIRD, ANGLE_W'(0)};

  logic [ANGLE_W-1:0] ang_s;
  logic [ANGLE_W-1:0] ang_c;
  logic [PROD_W-1:0]  prod_s;
  logic [PROD_W-1:0]  prod_c;

  // index = (angle * depth) >> 16, angles wrap modulo one turn
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ang_s      = rotor_angle + PHASE_OFS[k];
      ang_c      = ang_s + ANGLE_QUARTER;
      prod_s     = PROD_W'(ang_s) * PROD_W'(SINE_TABLE_DEPTH);
      prod_c     = PROD_W'(ang_c) * PROD_W'(SINE_TABLE_DEPTH);
      sin_idx[k] = prod_s[ANGLE_W +: IDX_W];
      cos_idx[k] = prod_c[ANGLE_W +: IDX_W];
    end
  end

endmodule

// File: src/act_scale_sat.sv
// ---------------------------------------------------------------------------
// act_scale_sat
// One output axis: sums three phase products, scales by 2/3 of full scale
// with round-to-nearest (ties away from zero) and saturates to the sample
// width. Four register stages: sum, round, reciprocal multiply, output.
// ---------------------------------------------------------------------------
module act_scale_sat #(
  parameter int SAMPLE_BITS = act_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                          clk,
  input  act_pkg::scale_ctrl_t                          ctrl,
  input  logic signed [SAMPLE_BITS+act_pkg::SINE_W-1:0] prod_a,
  input  logic signed [SAMPLE_BITS+act_pkg::SINE_W-1:0] prod_b,
  input  logic signed [SAMPLE_BITS+act_pkg::SINE_W-1:0] prod_c,
  output logic signed [SAMPLE_BITS-1:0]                 result
);
  import act_pkg::*;

  localparam int PROD_W     = SAMPLE_BITS + SINE_W;
  localparam int ACC_W      = PROD_W + 2;
  // 2*acc/(3*2^15) rounded = floor((|acc| + 3*2^13) / 2^14) / 3
  localparam int ROUND_SH   = 14;
  localparam int M_W        = ACC_W - ROUND_SH;
  localparam int N_W        = SAMPLE_BITS + 1;
  localparam int DIV_SH     = SAMPLE_BITS + 2;
  localparam int QP_W       = 2 * N_W;

  localparam logic [ACC_W-1:0] ROUND_POS = ACC_W'(24576);
  localparam logic [ACC_W-1:0] ROUND_NEG = ACC_W'(24577);   // folds the +1 of negation
  localparam logic [M_W-1:0]   SAT_LIM   = M_W'(3) << (SAMPLE_BITS - 1);
  localparam logic [N_W-1:0]   RECIP     =
    N_W'(((64'd1 << DIV_SH) + 64'd2) / 64'd3);

  localparam logic signed [SAMPLE_BITS-1:0] RES_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] RES_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [ACC_W-1:0] acc;
  logic                    acc_neg;
  logic [ACC_W-1:0]        mag_round;
  logic [M_W-1:0]          m_full;

  logic [N_W-1:0]          m_val;
  logic                    neg_r;
  logic                    sat_r;

  logic [QP_W-1:0]         quot_prod;
  logic                    neg_m;
  logic                    sat_m;

  logic [SAMPLE_BITS-2:0]  quot;

  // Sum stage
  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      acc <= ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_c);
    end
  end

  // Magnitude plus rounding offset in one add
  assign acc_neg   = acc[ACC_W-1];
  assign mag_round = acc_neg ? (~acc + ROUND_NEG) : (acc + ROUND_POS);
  assign m_full    = mag_round[ACC_W-1:ROUND_SH];

  // Round stage: saturation decided before the divide by three
  always_ff @(posedge clk) begin
    if (ctrl.round_en) begin
      m_val <= m_full[N_W-1:0];
      neg_r <= acc_neg;
      sat_r <= (m_full >= SAT_LIM);
    end
  end

  // Divide by three through reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      quot_prod <= QP_W'(m_val) * QP_W'(RECIP);
      neg_m     <= neg_r;
      sat_m     <= sat_r;
    end
  end

  assign quot = quot_prod[DIV_SH +: (SAMPLE_BITS - 1)];

  // Output stage: restore sign, clamp
  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      if (sat_m) begin
        result <= neg_m ? RES_MIN : RES_MAX;
      end else if (neg_m) begin
        result <= -$signed({1'b0, quot});
      end else begin
        result <= $signed({1'b0, quot});
      end
    end
  end

endmodule

// File: src/abc_to_dq_current_transform_top.sv
// ---------------------------------------------------------------------------
// abc_to_dq_current_transform_top
// Park transform of three phase currents into direct and quadrature
// currents, sine convention, pipelined for one transfer per clock.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries three signed phase currents
//   and an unsigned electrical angle (fraction of one turn). Output channel
//   (out_valid/out_ready) carries the d and q currents, signed, saturated.
//   Path: the input transfer loads stage 0, the item then moves through
//   stages 1 to 6 in order, and out_valid is the valid bit of stage 6.
//   Throughput: one item per clock without stalls. Each item needs six table
//   reads, served by three dual-read copies of the sine table in one stage.
//   Stall: a stage advances when it is empty or the stage after it moves,
//   so bubbles collapse and a held output still lets upstream stages fill.
//   With all seven stages full and out_ready low, in_ready drops; nothing
//   is lost or repeated.
//   Reset (rst, synchronous): clears all stage valid bits; in_ready is high
//   in the cycle after reset is released.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abc_to_dq_current_transform_top #(
  parameter int SINE_TABLE_DEPTH = act_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int SAMPLE_BITS      = act_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     phase_a_current,
  input  logic signed [SAMPLE_BITS-1:0]     phase_b_current,
  input  logic signed [SAMPLE_BITS-1:0]     phase_c_current,
  input  logic [act_pkg::ANGLE_W-1:0]       rotor_angle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     direct_current,
  output logic signed [SAMPLE_BITS-1:0]     quadrature_current
);
  import act_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = SAMPLE_BITS + SINE_W;

  // Stage map: 0 index, 1 table read, 2 products, 3..6 scaling per axis
  logic [PIPE_STAGES-1:0] stage_valid;
  logic [PIPE_STAGES-1:0] stage_ready;

  logic [2:0][IDX_W-1:0]           sin_idx;
  logic [2:0][IDX_W-1:0]           cos_idx;
  logic [2:0][IDX_W-1:0]           sin_idx_r;
  logic [2:0][IDX_W-1:0]           cos_idx_r;
  logic signed [SAMPLE_BITS-1:0]   samp0 [3];
  logic signed [SAMPLE_BITS-1:0]   samp1 [3];
  logic signed [SINE_W-1:0]        sin_val [3];
  logic signed [SINE_W-1:0]        cos_val [3];
  logic signed [PROD_W-1:0]        prod_sin [3];
  logic signed [PROD_W-1:0]        prod_cos [3];
  scale_ctrl_t                     scale_ctrl;

  // Stage ready chain: a stage loads when empty or when its successor moves
  always_comb begin
    stage_ready[PIPE_STAGES-1] = !stage_valid[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[PIPE_STAGES-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= (stage_ready & {stage_valid[PIPE_STAGES-2:0], in_valid})
                   | (~stage_ready & stage_valid);
    end
  end

  // Stage 0: phase angles to table indices
  act_phase_index #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_phase_index (
    .rotor_angle (rotor_angle),
    .sin_idx     (sin_idx),
    .cos_idx     (cos_idx)
  );

  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      sin_idx_r <= sin_idx;
      cos_idx_r <= cos_idx;
      samp0[0]  <= phase_a_current;
      samp0[1]  <= phase_b_current;
      samp0[2]  <= phase_c_current;
    end
  end

  // Stage 1: one table copy per phase, sine and cosine ports
  for (genvar k = 0; k < 3; k++) begin : g_phase
    act_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
      .clk    (clk),
      .rd_en  (stage_ready[1]),
      .addr_a (sin_idx_r[k]),
      .addr_b (cos_idx_r[k]),
      .data_a (sin_val[k]),
      .data_b (cos_val[k])
    );
  end

  always_ff @(posedge clk) begin
    if (stage_ready[1]) begin
      samp1 <= samp0;
    end
  end

  // Stage 2: sample times sine and cosine
  always_ff @(posedge clk) begin
    if (stage_ready[2]) begin
      for (int k = 0; k < 3; k++) begin
        prod_sin[k] <= PROD_W'(samp1[k]) * PROD_W'(sin_val[k]);
        prod_cos[k] <= PROD_W'(samp1[k]) * PROD_W'(cos_val[k]);
      end
    end
  end

  // Stages 3..6: scaling and saturation per axis
  assign scale_ctrl.sum_en   = stage_ready[3];
  assign scale_ctrl.round_en = stage_ready[4];
  assign scale_ctrl.mul_en   = stage_ready[5];
  assign scale_ctrl.out_en   = stage_ready[6];

  act_scale_sat #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale_d (
    .clk    (clk),
    .ctrl   (scale_ctrl),
    .prod_a (prod_sin[0]),
    .prod_b (prod_sin[1]),
    .prod_c (prod_sin[2]),
    .result (direct_current)
  );

  act_scale_sat #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale_q (
    .clk    (clk),
    .ctrl   (scale_ctrl),
    .prod_a (prod_cos[0]),
    .prod_b (prod_cos[1]),
    .prod_c (prod_cos[2]),
    .result (quadrature_current)
  );

  // Checks
  `ACT_ASSERT_NR(a_reset_clears, clk, rst |=> !out_valid && !stage_valid[0], "valid after reset")
  `ACT_ASSERT(a_accept_enters, clk, rst, in_valid && in_ready |=> stage_valid[0], "transfer lost")
  `ACT_ASSERT(a_empty_out_ready, clk, rst, !out_valid |-> in_ready, "input blocked while empty")
  `ACT_ASSERT(a_full_blocks, clk, rst, (&stage_valid) && !out_ready |-> !in_ready, "overrun")

endmodule

// File: sim/abc_to_dq_current_transform_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// abc_to_dq_current_transform_top_tb
// Self-checking bench for the abc-to-dq current transform. A short table of
// hand-picked samples (zero, full-scale, saturating and wrap-around angles)
// is followed by about 1200 random samples under three idle mixes and one
// long output hold. Typed rows are compared against their own d/q; others
// against a local fixed-point model of the sine table and 2/3 projection.
// ---------------------------------------------------------------------------
module abc_to_dq_current_transform_top_tb;

  localparam int SMP_W       = act_pkg::DEF_SAMPLE_BITS;
  localparam int DEPTH       = act_pkg::DEF_SINE_TABLE_DEPTH;
  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTS  = 100;
  localparam longint DEN     = 3 * 32768;

  localparam logic signed [SMP_W-1:0] I_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] I_MIN = 16'sh8000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]          ia;
    logic signed [SMP_W-1:0]          ib;
    logic signed [SMP_W-1:0]          ic;
    logic [act_pkg::ANGLE_W-1:0]      angle;
  } phase_sample_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] direct;
    logic signed [SMP_W-1:0] quadrature;
  } dq_current_t;

  typedef struct {
    phase_sample_t smp;
    bit            typed;
    dq_current_t   dq;
  } directed_row_t;

  localparam dq_current_t ZERO_DQ = '0;

  // DUT signals
  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SMP_W-1:0]       phase_a_current;
  logic signed [SMP_W-1:0]       phase_b_current;
  logic signed [SMP_W-1:0]       phase_c_current;
  logic [act_pkg::ANGLE_W-1:0]   rotor_angle;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SMP_W-1:0]       direct_current;
  logic signed [SMP_W-1:0]       quadrature_current;

  // Hand-typed result riding along with the payload (directed rows only)
  logic        offer_typed;
  dq_current_t offer_typed_dq;

  // Bench state
  int          sine_q15 [DEPTH];
  dq_current_t expected_dq_q [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          err_count;
  int          n_in;
  int          n_out;
  int          n_saturated;
  int          n_in_stall;

  // Directed samples; only zero-current rows carry a typed result
  directed_row_t stim_rows [23] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'd0},         1'b1, ZERO_DQ},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'd65535},     1'b1, ZERO_DQ},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'd16384},     1'b1, ZERO_DQ},
    '{'{I_MAX, 16'sd0, 16'sd0, 16'd0},          1'b0, ZERO_DQ},
    '{'{I_MAX, 16'sd0, 16'sd0, 16'd16384},      1'b0, ZERO_DQ},
    '{'{I_MIN, 16'sd0, 16'sd0, 16'd32768},      1'b0, ZERO_DQ},
    '{'{16'sd0, I_MAX, 16'sd0, 16'd21845},      1'b0, ZERO_DQ},
    '{'{16'sd0, I_MIN, 16'sd0, 16'd49152},      1'b0, ZERO_DQ},
    '{'{16'sd0, 16'sd0, I_MAX, 16'd43690},      1'b0, ZERO_DQ},
    '{'{16'sd0, 16'sd0, I_MIN, 16'd65535},      1'b0, ZERO_DQ},
    // d saturates high / low at 90 deg, q at 0 deg
    '{'{I_MAX, I_MIN, I_MIN, 16'd16384},        1'b0, ZERO_DQ},
    '{'{I_MIN, I_MAX, I_MAX, 16'd16384},        1'b0, ZERO_DQ},
    '{'{I_MAX, I_MIN, I_MIN, 16'd0},            1'b0, ZERO_DQ},
    '{'{I_MIN, I_MAX, I_MAX, 16'd0},            1'b0, ZERO_DQ},
    // balanced zero-sequence input
    '{'{I_MAX, I_MAX, I_MAX, 16'd1000},         1'b0, ZERO_DQ},
    '{'{I_MIN, I_MIN, I_MIN, 16'd30000},        1'b0, ZERO_DQ},
    // table index boundaries
    '{'{16'sd1, -16'sd1, 16'sd0, 16'd63},       1'b0, ZERO_DQ},
    '{'{16'sd1, -16'sd1, 16'sd0, 16'd64},       1'b0, ZERO_DQ},
    '{'{-16'sd1, 16'sd1, -16'sd1, 16'd65472},   1'b0, ZERO_DQ},
    // alternating bit patterns
    '{'{16'sd21845, -16'sd21846, 16'sd0, 16'hAAAA},      1'b0, ZERO_DQ},
    '{'{-16'sd21846, 16'sd21845, 16'sd10922, 16'h5555},  1'b0, ZERO_DQ},
    // angle minus / plus 120 deg wraps around the turn
    '{'{I_MAX, I_MAX, I_MIN, 16'd21844},        1'b0, ZERO_DQ},
    '{'{I_MIN, I_MIN, I_MAX, 16'd43691},        1'b0, ZERO_DQ}
  };

  abc_to_dq_current_transform_top u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .phase_a_current    (phase_a_current),
    .phase_b_current    (phase_b_current),
    .phase_c_current    (phase_c_current),
    .rotor_angle        (rotor_angle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .direct_current     (direct_current),
    .quadrature_current (quadrature_current)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Fixed-point model of the transform
  // -------------------------------------------------------------------------

  // First-quadrant sine: Q30 Taylor series, truncating, rounded to Q15
  function automatic int quarter_sine(u64_t r);
    u64_t   theta;
    u64_t   theta2;
    u64_t   term;
    longint acc;
    theta  = (u64_t'(act_pkg::HALF_PI_Q30) * r) / u64_t'(DEPTH);
    theta2 = (theta * theta) >> 30;
    term   = theta;
    acc    = longint'(theta);
    for (u64_t n = 1; n <= 7; n++) begin
      term = ((term * theta2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n[0]) acc -= longint'(term);
      else      acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    return int'((u64_t'(acc) * 32767 + (u64_t'(1) << 29)) >> 30);
  endfunction

  // Full-turn table built from quadrant symmetry
  initial begin
    u64_t u;
    u64_t quad;
    u64_t r;
    int   v;
    for (int k = 0; k < DEPTH; k++) begin
      u    = 4 * u64_t'(k);
      quad = u / DEPTH;
      r    = u % DEPTH;
      v    = quad[0] ? quarter_sine(DEPTH - r) : quarter_sine(r);
      sine_q15[k] = (quad >= 2) ? -v : v;
    end
  end

  function automatic longint sine_lookup(logic [act_pkg::ANGLE_W-1:0] ang);
    u64_t idx;
    idx = (u64_t'(ang) * DEPTH) >> 16;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return longint'(sine_q15[idx]);
  endfunction

  // 2/3 projection onto one axis, round half away from zero, saturate
  function automatic logic signed [SMP_W-1:0] project_axis(
      longint a, longint b, longint c, logic [act_pkg::ANGLE_W-1:0] ang);
    logic [act_pkg::ANGLE_W-1:0] ang_lag;
    logic [act_pkg::ANGLE_W-1:0] ang_lead;
    longint acc;
    longint mag;
    longint q;
    ang_lag  = ang - act_pkg::ANGLE_THIRD;
    ang_lead = ang + act_pkg::ANGLE_THIRD;
    acc = a * sine_lookup(ang) + b * sine_lookup(ang_lag) + c * sine_lookup(ang_lead);
    acc = 2 * acc;
    mag = (acc < 0) ? -acc : acc;
    q   = (mag + DEN / 2) / DEN;
    if (acc < 0) q = -q;
    if (q > longint'(I_MAX)) q = longint'(I_MAX);
    if (q < longint'(I_MIN)) q = longint'(I_MIN);
    return q[SMP_W-1:0];
  endfunction

  function automatic dq_current_t predict_dq(phase_sample_t s);
    dq_current_t r;
    logic [act_pkg::ANGLE_W-1:0] ang_q;
    ang_q = s.angle + act_pkg::ANGLE_QUARTER;
    r.direct     = project_axis(longint'(s.ia), longint'(s.ib), longint'(s.ic), s.angle);
    r.quadrature = project_axis(longint'(s.ia), longint'(s.ib), longint'(s.ic), ang_q);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  task automatic report_error(string msg);
    err_count++;
    // keep the log bounded on a badly broken build
    if (err_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Record input transfers and check output transfers
  always @(posedge clk) begin
    phase_sample_t smp;
    dq_current_t   got;
    dq_current_t   exp_dq;
    if (!rst) begin
      if (in_valid && !in_ready) n_in_stall++;
      if (in_valid && in_ready) begin
        smp = '{phase_a_current, phase_b_current, phase_c_current, rotor_angle};
        expected_dq_q.push_back(offer_typed ? offer_typed_dq : predict_dq(smp));
        n_in++;
      end
      if (out_valid && out_ready) begin
        got = '{direct_current, quadrature_current};
        if (expected_dq_q.size() == 0) begin
          report_error($sformatf("result %0d with nothing pending (d=%0d q=%0d)",
                                 n_out, got.direct, got.quadrature));
        end else begin
          exp_dq = expected_dq_q.pop_front();
          if (got.direct !== exp_dq.direct)
            report_error($sformatf("result %0d direct_current got %0d exp %0d",
                                   n_out, got.direct, exp_dq.direct));
          if (got.quadrature !== exp_dq.quadrature)
            report_error($sformatf("result %0d quadrature_current got %0d exp %0d",
                                   n_out, got.quadrature, exp_dq.quadrature));
        end
        if (got.direct == I_MAX || got.direct == I_MIN ||
            got.quadrature == I_MAX || got.quadrature == I_MIN)
          n_saturated++;
        n_out++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    int idle_run;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles, %0d results pending",
                 STALL_LIMIT, expected_dq_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: decide at the rising edge, drive at the falling edge
  // -------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit ready_next;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
      out_ready <= ready_next;
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_sample(phase_sample_t s, bit typed, dq_current_t typed_dq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    phase_a_current <= s.ia;
    phase_b_current <= s.ib;
    phase_c_current <= s.ic;
    rotor_angle     <= s.angle;
    offer_typed     <= typed;
    offer_typed_dq  <= typed_dq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Biased current: full-scale and zero often, small values, else anything
  function automatic logic signed [SMP_W-1:0] random_current();
    case ($urandom_range(7))
      0:       return I_MAX;
      1:       return I_MIN;
      2:       return '0;
      3:       return SMP_W'(int'($urandom_range(512)) - 256);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Biased angle: near the quadrant points, the last angle before wrap, or fully random
  function automatic logic [act_pkg::ANGLE_W-1:0] random_angle();
    case ($urandom_range(5))
      0:       return act_pkg::ANGLE_W'($urandom_range(3) * 16384 + $urandom_range(127) - 64);
      1:       return '1;
      default: return act_pkg::ANGLE_W'($urandom);
    endcase
  endfunction

  initial begin
    phase_sample_t s;
    err_count = 0;
    n_in = 0;
    n_out = 0;
    n_saturated = 0;
    n_in_stall = 0;
    hold_req = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 47;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    phase_a_current <= '0;
    phase_b_current <= '0;
    phase_c_current <= '0;
    rotor_angle     <= '0;
    offer_typed     <= 1'b0;
    offer_typed_dq  <= ZERO_DQ;
    // hold reset high, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (stim_rows[i])
      offer_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].dq);

    // Random samples in three idle mixes; the last one opens with an output hold
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 7;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end
      s.ia    = random_current();
      s.ib    = random_current();
      s.ic    = random_current();
      s.angle = random_angle();
      offer_sample(s, 1'b0, ZERO_DQ);
    end
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray results
    while (expected_dq_q.size() != 0) @(posedge clk);
    repeat (2 * act_pkg::PIPE_STAGES + 4) @(posedge clk);

    $display("Covered %0d directed and %0d random samples: %0d in, %0d out, %0d saturated",
             $size(stim_rows), RAND_ITEMS, n_in, n_out, n_saturated);
    $display("Idle mixes 7/47, 47/7 and none, plus a %0d-cycle output hold (%0d input stalls)",
             HOLD_CYCLES, n_in_stall);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
